@@ design/rmj_pkg.sv @@
// Shared types and constants for the radar measurement Jacobian pipeline.
package rmj_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 6;
    localparam int NUM_W         = 128;
    localparam int Q_W           = 32;

    // Values that ride alongside the square-root chain.
    typedef struct packed {
        logic [63:0]      r2;
        logic [31:0]      mpx;
        logic [31:0]      mpy;
        logic [95:0]      nx;
        logic [95:0]      ny;
        logic [LANES-1:0] neg;
        logic             err;
    } sd_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] res;
        sd_t         side;
    } sq_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] rem;
        logic [LANES-1:0][Q_W-1:0]   q;
        logic [LANES-1:0]            ovf;
        logic [LANES-1:0]            neg;
        logic [31:0]                 dr;
        logic [63:0]                 dr2;
        logic [95:0]                 dr3;
        logic                        err;
    } dv_t;

    typedef struct packed {
        logic [LANES-1:0][Q_W-1:0] q;
        logic                      err;
    } res_t;

endpackage

@@ design/radar_measurement_jacobian_core.sv @@
// Radar measurement Jacobian: top level with front multipliers, cell chains and output skid.
//
// Takes one state (pos_x, pos_y, vel_x, vel_y, signed fixed point with FRAC_BITS fraction
// bits) per transfer and returns the six distinct Jacobian entries of range, bearing and
// range rate: px/r, py/r, -py/r^2, px/r^2 and the two range-rate position terms, each
// truncated toward zero and saturated to 32 bits. A new state is taken every clock while
// in_stall is low. A state passes 4 front stages (input capture and multipliers), a chain of
// 32 square-root cells giving one range bit each, 3 stages forming r^3 and the numerators,
// a chain of 32 divider cells giving one quotient bit of all six quotients each, and the
// output register. When r^2 falls below min_range_squared (FRAC_BITS fraction bits, shifted
// left by FRAC_BITS) or is zero, near_zero_error is set and all entries are zero. in_stall
// rises only when both the output register and its skid slot hold results. Configuration is
// written via cfg_wr_en / cfg_wr_data by the user while the pipeline is empty; not enforced.
module radar_measurement_jacobian_core #(
    parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] range_by_px,
    output logic [31:0] range_by_py,
    output logic [31:0] bearing_by_px,
    output logic [31:0] bearing_by_py,
    output logic [31:0] rate_by_px,
    output logic [31:0] rate_by_py,
    output logic        near_zero_error
);
    import rmj_pkg::*;

    localparam int SQ_CELLS  = 32;
    localparam int DIV_CELLS = Q_W;

    // configuration
    logic [15:0] min_r2_reg;

    // pipeline advance: everything moves unless the skid slot is occupied
    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;

    // stage 1: captured input
    logic        s1_valid_reg;
    logic [31:0] px_reg, py_reg, vx_reg, vy_reg;

    // stage 2: magnitudes and cross products
    logic               s2_valid_reg;
    logic [31:0]        mpx_reg, mpy_reg;
    logic               pxn_reg, pyn_reg;
    logic signed [63:0] t1_reg, t2_reg;

    // stage 3: squares and cross term in sign-magnitude
    logic        s3_valid_reg;
    logic [63:0] sqx_reg, sqy_reg;
    logic [63:0] cmag_reg;
    logic        cneg_reg;
    logic [31:0] mpx3_reg, mpy3_reg;
    logic        pxn3_reg, pyn3_reg;

    // stage 4: squared range, error check, rate-term partial products
    logic        s4_valid_reg;
    logic [63:0] r2_reg;
    logic [63:0] r2_next;
    logic        err_reg;
    logic [63:0] pyc_lo_reg, pyc_hi_reg, pxc_lo_reg, pxc_hi_reg;
    logic [31:0] mpx4_reg, mpy4_reg;
    logic [5:0]  neg4_reg;
    logic [5:0]  neg4_next;

    // square-root chain
    logic [SQ_CELLS:0] sq_v;
    sq_t               sq_d [SQ_CELLS+1];

    // stage r3a / r3b / numerator set-up
    logic        s6_valid_reg;
    logic [63:0] r3lo_reg, r3hi_reg;
    sd_t         s6_side_reg;
    logic [31:0] s6_r_reg;
    logic        s7_valid_reg;
    logic [95:0] r3_reg;
    sd_t         s7_side_reg;
    logic [31:0] s7_r_reg;

    // divider chain
    logic [DIV_CELLS:0] dv_v;
    dv_t                dv_d [DIV_CELLS+1];
    dv_t                dv_next;
    logic               s8_valid_reg;
    dv_t                s8_reg;

    // output side
    res_t tail_res;
    res_t out_reg;
    res_t skid_reg;
    logic take;
    logic tail_go;

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_r2_reg <= 16'd7;
        else if (cfg_wr_en)
            min_r2_reg <= cfg_wr_data;
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s6_valid_reg <= sq_v[SQ_CELLS];
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    assign r2_next = sqx_reg + sqy_reg;

    always_comb
    begin
        neg4_next[0] = pxn3_reg;
        neg4_next[1] = pyn3_reg;
        neg4_next[2] = !pyn3_reg;
        neg4_next[3] = pxn3_reg;
        neg4_next[4] = pyn3_reg ^ cneg_reg;
        neg4_next[5] = pxn3_reg ^ !cneg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            px_reg <= pos_x;
            py_reg <= pos_y;
            vx_reg <= vel_x;
            vy_reg <= vel_y;
            // stage 2
            mpx_reg <= px_reg[31] ? (32'd0 - px_reg) : px_reg;
            mpy_reg <= py_reg[31] ? (32'd0 - py_reg) : py_reg;
            pxn_reg <= px_reg[31];
            pyn_reg <= py_reg[31];
            t1_reg  <= $signed(vx_reg) * $signed(py_reg);
            t2_reg  <= $signed(vy_reg) * $signed(px_reg);
            // stage 3
            sqx_reg  <= mpx_reg * mpx_reg;
            sqy_reg  <= mpy_reg * mpy_reg;
            cneg_reg <= (t1_reg < t2_reg);
            cmag_reg <= (t1_reg >= t2_reg) ? (t1_reg - t2_reg) : (t2_reg - t1_reg);
            mpx3_reg <= mpx_reg;
            mpy3_reg <= mpy_reg;
            pxn3_reg <= pxn_reg;
            pyn3_reg <= pyn_reg;
            // stage 4
            r2_reg     <= r2_next;
            err_reg    <= (r2_next == 64'd0) || (r2_next < ({48'b0, min_r2_reg} << FRAC_BITS));
            pyc_lo_reg <= mpy3_reg * cmag_reg[31:0];
            pyc_hi_reg <= mpy3_reg * cmag_reg[63:32];
            pxc_lo_reg <= mpx3_reg * cmag_reg[31:0];
            pxc_hi_reg <= mpx3_reg * cmag_reg[63:32];
            mpx4_reg   <= mpx3_reg;
            mpy4_reg   <= mpy3_reg;
            neg4_reg   <= neg4_next;
        end
    end

    // stage 5 is the chain head: numerators of the rate terms assembled here
    always_comb
    begin
        sq_d[0].rem      = r2_reg;
        sq_d[0].res      = 32'd0;
        sq_d[0].side.r2  = r2_reg;
        sq_d[0].side.mpx = mpx4_reg;
        sq_d[0].side.mpy = mpy4_reg;
        sq_d[0].side.nx  = {32'b0, pyc_lo_reg} + ({32'b0, pyc_hi_reg} << 32);
        sq_d[0].side.ny  = {32'b0, pxc_lo_reg} + ({32'b0, pxc_hi_reg} << 32);
        sq_d[0].side.neg = neg4_reg;
        sq_d[0].side.err = err_reg;
    end
    assign sq_v[0] = s4_valid_reg;

    for (genvar i = 0; i < SQ_CELLS; i++)
    begin : g_sqrt
        rmj_sqrt_cell #(
            .BIT(SQ_CELLS - 1 - i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .a_valid(sq_v[i]),
            .a_data (sq_d[i]),
            .b_valid(sq_v[i+1]),
            .b_data (sq_d[i+1])
        );
    end

    // r^3 = r^2 * r in two 32-bit halves, then summed
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r3lo_reg    <= sq_d[SQ_CELLS].side.r2[31:0] * sq_d[SQ_CELLS].res;
            r3hi_reg    <= sq_d[SQ_CELLS].side.r2[63:32] * sq_d[SQ_CELLS].res;
            s6_side_reg <= sq_d[SQ_CELLS].side;
            s6_r_reg    <= sq_d[SQ_CELLS].res;
            r3_reg      <= {32'b0, r3lo_reg} + ({32'b0, r3hi_reg} << 32);
            s7_side_reg <= s6_side_reg;
            s7_r_reg    <= s6_r_reg;
            s8_reg      <= dv_next;
        end
    end

    // numerators and the quotient-overflow test (quotient >= 2^32)
    always_comb
    begin
        dv_next.rem[0] = {96'b0, s7_side_reg.mpx} << FRAC_BITS;
        dv_next.rem[1] = {96'b0, s7_side_reg.mpy} << FRAC_BITS;
        dv_next.rem[2] = {96'b0, s7_side_reg.mpy} << (2 * FRAC_BITS);
        dv_next.rem[3] = {96'b0, s7_side_reg.mpx} << (2 * FRAC_BITS);
        dv_next.rem[4] = {32'b0, s7_side_reg.nx} << FRAC_BITS;
        dv_next.rem[5] = {32'b0, s7_side_reg.ny} << FRAC_BITS;
        dv_next.ovf[0] = dv_next.rem[0] >= ({96'b0, s7_r_reg} << Q_W);
        dv_next.ovf[1] = dv_next.rem[1] >= ({96'b0, s7_r_reg} << Q_W);
        dv_next.ovf[2] = dv_next.rem[2] >= ({64'b0, s7_side_reg.r2} << Q_W);
        dv_next.ovf[3] = dv_next.rem[3] >= ({64'b0, s7_side_reg.r2} << Q_W);
        dv_next.ovf[4] = dv_next.rem[4] >= ({32'b0, r3_reg} << Q_W);
        dv_next.ovf[5] = dv_next.rem[5] >= ({32'b0, r3_reg} << Q_W);
        dv_next.q      = '0;
        dv_next.neg    = s7_side_reg.neg;
        dv_next.dr     = s7_r_reg;
        dv_next.dr2    = s7_side_reg.r2;
        dv_next.dr3    = r3_reg;
        dv_next.err    = s7_side_reg.err;
    end

    assign dv_v[0] = s8_valid_reg;
    assign dv_d[0] = s8_reg;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        rmj_div_cell #(
            .K(DIV_CELLS - 1 - i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .a_valid(dv_v[i]),
            .a_data (dv_d[i]),
            .b_valid(dv_v[i+1]),
            .b_data (dv_d[i+1])
        );
    end

    // saturate, apply sign, zero on near-zero range
    always_comb
    begin
        logic [Q_W-1:0] lim;
        logic [Q_W-1:0] mag;
        for (int j = 0; j < LANES; j++)
        begin
            lim = dv_d[DIV_CELLS].neg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            mag = (dv_d[DIV_CELLS].ovf[j] || (dv_d[DIV_CELLS].q[j] > lim))
                  ? lim : dv_d[DIV_CELLS].q[j];
            if (dv_d[DIV_CELLS].err)
                tail_res.q[j] = '0;
            else
                tail_res.q[j] = dv_d[DIV_CELLS].neg[j] ? (32'd0 - mag) : mag;
        end
        tail_res.err = dv_d[DIV_CELLS].err;
    end

    // output register with one skid slot behind it
    assign take    = out_valid_reg && !out_stall;
    assign tail_go = dv_v[DIV_CELLS] && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || tail_go;
            skid_valid_reg <= 1'b0;
        end
        else if (tail_go)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (tail_go)
                out_reg <= tail_res;
        end
        else if (tail_go)
        begin
            skid_reg <= tail_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign range_by_px     = out_reg.q[0];
    assign range_by_py     = out_reg.q[1];
    assign bearing_by_px   = out_reg.q[2];
    assign bearing_by_py   = out_reg.q[3];
    assign rate_by_px      = out_reg.q[4];
    assign rate_by_py      = out_reg.q[5];
    assign near_zero_error = out_reg.err;

    localparam logic [31:0] UNIT = 32'd1 << FRAC_BITS;

    // the skid slot is only used behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with empty output register");

    // a flagged near-zero range delivers all-zero entries
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && near_zero_error |-> (range_by_px == 32'd0) && (range_by_py == 32'd0)
            && (bearing_by_px == 32'd0) && (bearing_by_py == 32'd0)
            && (rate_by_px == 32'd0) && (rate_by_py == 32'd0))
        else $error("near-zero result with nonzero entries");

    // |px| and |py| never exceed the range, so the range row stays within one
    a_range_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((range_by_px[31] ? (32'd0 - range_by_px) : range_by_px) <= UNIT)
            && ((range_by_py[31] ? (32'd0 - range_by_py) : range_by_py) <= UNIT))
        else $error("range row entry beyond unity");

endmodule

@@ design/rmj_sqrt_cell.sv @@
// One bit of the restoring integer square root, with side values carried along.
module rmj_sqrt_cell #(
    parameter int BIT = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         a_valid,
    input  rmj_pkg::sq_t a_data,
    output logic         b_valid,
    output rmj_pkg::sq_t b_data
);
    import rmj_pkg::*;

    logic        valid_reg;
    sq_t         data_reg;
    sq_t         data_next;
    logic [65:0] trial;

    // (res + 2^BIT)^2 - res^2
    assign trial = ({34'b0, a_data.res} << (BIT + 1)) + (66'd1 << (2 * BIT));

    always_comb
    begin
        data_next = a_data;
        if ({2'b0, a_data.rem} >= trial)
        begin
            data_next.rem = a_data.rem - trial[63:0];
            data_next.res = a_data.res | (32'd1 << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= a_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign b_valid = valid_reg;
    assign b_data  = data_reg;

endmodule

@@ design/rmj_div_cell.sv @@
// One quotient bit of the six restoring divisions.
module rmj_div_cell #(
    parameter int K = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         a_valid,
    input  rmj_pkg::dv_t a_data,
    output logic         b_valid,
    output rmj_pkg::dv_t b_data
);
    import rmj_pkg::*;

    logic                        valid_reg;
    dv_t                         data_reg;
    dv_t                         data_next;
    logic [LANES-1:0][NUM_W-1:0] den;
    logic [LANES-1:0][NUM_W-1:0] den_sh;

    always_comb
    begin
        data_next = a_data;
        for (int j = 0; j < LANES; j++)
        begin
            if (j < 2)
                den[j] = {96'b0, a_data.dr};
            else if (j < 4)
                den[j] = {64'b0, a_data.dr2};
            else
                den[j] = {32'b0, a_data.dr3};
            den_sh[j] = den[j] << K;
            if (a_data.rem[j] >= den_sh[j])
            begin
                data_next.rem[j] = a_data.rem[j] - den_sh[j];
                data_next.q[j]   = {a_data.q[j][Q_W-2:0], 1'b1};
            end
            else
            begin
                data_next.q[j]   = {a_data.q[j][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= a_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign b_valid = valid_reg;
    assign b_data  = data_reg;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the radar measurement Jacobian core.
module testbench;
    import rmj_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = 80;
    localparam int MAX_CYCLE = 400000;

    typedef struct {
        logic [31:0] rpx, rpy, bpx, bpy, dpx, dpy;
        logic        err;
    } jac_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [31:0] range_by_px, range_by_py, bearing_by_px, bearing_by_py;
    logic [31:0] rate_by_px, rate_by_py;
    logic        near_zero_error;

    jac_t        jac_due[$];
    logic [15:0] min_r2 = 16'd7;
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_near = 0;
    int          cycles = 0;
    int          tx_gap_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_holdoff = 0;

    radar_measurement_jacobian_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .range_by_px(range_by_px), .range_by_py(range_by_py),
        .bearing_by_px(bearing_by_px), .bearing_by_py(bearing_by_py),
        .rate_by_px(rate_by_px), .rate_by_py(rate_by_py),
        .near_zero_error(near_zero_error)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [31:0] res;
        logic [31:0] cand;
        res = '0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = res | (32'd1 << i);
            if ({32'd0, cand} * {32'd0, cand} <= {64'd0, v})
                res = cand;
        end
        return res;
    endfunction

    // Truncating quotient, saturated to the signed 32-bit range.
    function automatic logic [31:0] sat_div(logic neg, logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        logic [127:0] lim;
        q   = num / den;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
            q = lim;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic jac_t jacobian(logic [31:0] px, logic [31:0] py,
                                      logic [31:0] vx, logic [31:0] vy, logic [15:0] thr);
        jac_t              j;
        logic [31:0]       mpx, mpy, r;
        logic [63:0]       r2, cmag;
        logic [127:0]      r3;
        logic signed [63:0] t1, t2;
        logic signed [64:0] cross_term;
        logic              pxn, pyn, cneg;
        pxn = px[31];
        pyn = py[31];
        mpx = pxn ? -px : px;
        mpy = pyn ? -py : py;
        r2  = {32'd0, mpx} * {32'd0, mpx} + {32'd0, mpy} * {32'd0, mpy};
        j = '{default: '0};
        if (r2 == 0 || r2 < ({48'd0, thr} << FB))
        begin
            j.err = 1'b1;
            return j;
        end
        r          = floor_sqrt(r2);
        r3         = {64'd0, r2} * {96'd0, r};
        t1         = $signed(vx) * $signed(py);
        t2         = $signed(vy) * $signed(px);
        cross_term = {t1[63], t1} - {t2[63], t2};
        cneg       = cross_term[64];
        cmag       = cneg ? 64'(-cross_term) : 64'(cross_term);
        j.rpx = sat_div(pxn, {96'd0, mpx} << FB, {96'd0, r});
        j.rpy = sat_div(pyn, {96'd0, mpy} << FB, {96'd0, r});
        j.bpx = sat_div(!pyn, {96'd0, mpy} << (2 * FB), {64'd0, r2});
        j.bpy = sat_div(pxn, {96'd0, mpx} << (2 * FB), {64'd0, r2});
        j.dpx = sat_div(pyn != cneg, ({64'd0, cmag} * {96'd0, mpy}) << FB, r3);
        j.dpy = sat_div(pxn != !cneg, ({64'd0, cmag} * {96'd0, mpx}) << FB, r3);
        return j;
    endfunction

    // Prediction on each input transfer, comparison on each output transfer.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            jac_due.push_back(jacobian(pos_x, pos_y, vel_x, vel_y, min_r2));
        if (rst_n && out_valid && !out_stall)
        begin
            if (jac_due.size() == 0)
            begin
                $display("%0t: result with nothing expected", $time);
                errors++;
            end
            else
            begin
                jac_t e;
                e = jac_due.pop_front();
                n_checked++;
                if (e.err) n_near++;
                if (e.rpx !== range_by_px)
                begin
                    $display("%0t: range_by_px exp %h got %h", $time, e.rpx, range_by_px);
                    errors++;
                end
                if (e.rpy !== range_by_py)
                begin
                    $display("%0t: range_by_py exp %h got %h", $time, e.rpy, range_by_py);
                    errors++;
                end
                if (e.bpx !== bearing_by_px)
                begin
                    $display("%0t: bearing_by_px exp %h got %h", $time, e.bpx, bearing_by_px);
                    errors++;
                end
                if (e.bpy !== bearing_by_py)
                begin
                    $display("%0t: bearing_by_py exp %h got %h", $time, e.bpy, bearing_by_py);
                    errors++;
                end
                if (e.dpx !== rate_by_px)
                begin
                    $display("%0t: rate_by_px exp %h got %h", $time, e.dpx, rate_by_px);
                    errors++;
                end
                if (e.dpy !== rate_by_py)
                begin
                    $display("%0t: rate_by_py exp %h got %h", $time, e.dpy, rate_by_py);
                    errors++;
                end
                if (e.err !== near_zero_error)
                begin
                    $display("%0t: near_zero_error exp %b got %b", $time, e.err,
                             near_zero_error);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is armed.
    always @(negedge clk)
    begin
        if (rx_holdoff > 0)
        begin
            out_stall  <= 1'b1;
            rx_holdoff <= rx_holdoff - 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL radar_measurement_jacobian_core");
            $finish;
        end
    end

    // Valid stays high between back-to-back transfers; dropped only for gaps.
    task automatic send_state(logic [31:0] px, logic [31:0] py,
                              logic [31:0] vx, logic [31:0] vy);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= px;
        pos_y    <= py;
        vel_x    <= vx;
        vel_y    <= vy;
        do @(posedge clk); while (in_stall);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (jac_due.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic set_min_range(logic [15:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        min_r2 = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom()) >>> $urandom_range(31));
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return 32'($signed($urandom()) >>> 12);
        endcase
    endfunction

    task automatic test_corner_states();
        set_min_range(16'd0);
        send_state(32'd0, 32'd0, 32'd5, 32'd7);                 // zero range, zero threshold
        send_state(32'd1, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000); // tiny range: saturation
        send_state(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1);
        send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_state(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_state(32'hFFFF_0000, 32'd0, 32'd0, 32'h0003_0000);
        send_state(32'h0003_0000, 32'h0004_0000, 32'h0004_0000, 32'h0003_0000); // 3-4-5 triangle: range of exactly 5
        set_min_range(16'd7);
        send_state(32'd0, 32'd0, 32'd0, 32'd0);
        send_state(32'h0000_02A6, 32'd0, 32'd1, 32'd1);         // just above threshold
        send_state(32'h0000_02A5, 32'd0, 32'd1, 32'd1);         // just below
        send_state(32'hFFFF_FD5B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        set_min_range(16'hFFFF);
        send_state(32'h00FF_FF80, 32'd0, 32'h1234_5678, 32'h8765_4321);
        send_state(32'h0100_0000, 32'd0, 32'h1234_5678, 32'h8765_4321);
        send_state(32'h8000_0000, 32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_random_states(int n);
        for (int i = 0; i < n; i++)
            send_state(rand_coord(), rand_coord(), $urandom(), rand_coord());
    endtask

    task automatic test_full_pipeline();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_holdoff   = 400;
        test_random_states(150);
        drain();
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_corner_states();

        tx_gap_pct = 19; rx_stall_pct = 83;
        test_random_states(300);
        set_min_range(16'd1);
        tx_gap_pct = 83; rx_stall_pct = 19;
        test_random_states(300);
        set_min_range(16'($urandom()));
        tx_gap_pct = 0; rx_stall_pct = 0;
        test_random_states(300);
        set_min_range(16'd7);
        test_full_pipeline();
        set_min_range(16'd0);
        tx_gap_pct = 10; rx_stall_pct = 10;
        test_random_states(300);
        drain();

        $display("Sent %0d states across several threshold settings, %0d results checked.",
                 n_sent, n_checked);
        $display("%0d near-zero-range results; stalls, gaps and a long hold-off exercised.",
                 n_near);
        if (errors == 0 && jac_due.size() == 0)
            $display("PASS radar_measurement_jacobian_core");
        else
            $display("FAIL radar_measurement_jacobian_core");
        $finish;
    end
endmodule
